[sv/platform_event_filter_match_core_defines.svh]
// Assertion macros used by the event filter core.
// No dependencies.
`ifndef PLATFORM_EVENT_FILTER_MATCH_CORE_DEFINES_SVH
`define PLATFORM_EVENT_FILTER_MATCH_CORE_DEFINES_SVH
// Check prop on every rising clock edge outside reset.
`define PEFM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond implies prop in the following cycle.
`define PEFM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

[sv/pefm_pkg.sv]
// Types, constants and the data rule and ID match functions of the event filter.
// No dependencies.
package pefm_pkg;
  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned MAX_HITS = 31;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_MATCH   = 2'd1;
  localparam logic [1:0] KIND_NOMATCH = 2'd2;
  localparam logic [1:0] KIND_OFF     = 2'd3;

  localparam logic [1:0] REG_FILTER_CTRL = 2'd0;
  localparam logic [1:0] REG_POSTPONE    = 2'd1;
  localparam logic [1:0] REG_ACTION_EN   = 2'd2;

  localparam logic [4:0] FLD_TRIGGER  = 5'd5;
  localparam logic [4:0] FLD_D1_MASK  = 5'd6;
  localparam logic [4:0] FLD_D2_MASK  = 5'd9;
  localparam logic [4:0] FLD_D3_MASK  = 5'd12;
  localparam logic [4:0] FLD_OFFSET   = 5'd15;
  localparam logic [4:0] FLD_ACTION   = 5'd16;
  localparam logic [4:0] FLD_SEVERITY = 5'd18;

  typedef struct packed {
    logic        en;
    logic [4:0]  entry;
    logic [4:0]  field;
    logic [15:0] value;
  } wr_t;

  typedef struct packed {
    logic [7:0]  st;
    logic [7:0]  sn;
    logic [7:0]  et;
    logic [15:0] gid;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  d3;
  } ev_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] act;
    logic [3:0] pol;
    logic [7:0] sev;
  } slot_t;

  function automatic logic rule_pass(input logic [7:0] v, input logic [23:0] rule);
    logic [7:0] m, c1, c2, t1, t2;
    logic       hit, chk;
    m  = rule[7:0];
    c1 = rule[15:8];
    c2 = rule[23:16];
    t1 = v & m;
    t2 = t1 & ~c1;
    hit = 1'b1;
    chk = 1'b1;
    if ((t1 & c1) != (c2 & c1)) begin
      hit = 1'b0;
    end else if (c1 != 8'hFF) begin
      if (c2 != 8'h00) begin
        if ((t2 & c2) == 8'h00) hit = 1'b0;
        else chk = 1'b0;
      end
      if (chk && (c2 != 8'hFF)) hit = ((~(t2 | c1)) & (~c2)) != 8'h00;
    end
    return hit;
  endfunction

  function automatic logic id_ok(input logic [7:0] want, input logic [7:0] got);
    return (want == 8'hFF) || (want == got);
  endfunction
endpackage

[sv/platform_event_filter_match_core.sv]
// Event filter table and matcher: a row of entry cells plus scan control.
// A write or filtered-off event answers in the cycle after accept, one per cycle unless the output stalls.
// An event loads all cells, then the chain shifts one entry per cycle to the head while
// the output is free; the scan ends on the last entry, or earlier on a hit that is last,
// and a new transaction is accepted only once the scan is back in idle.
// Reset (async, active low) clears the table, registers and control at once.
module platform_event_filter_match_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [4:0]  entry_index_i,
  input  logic [4:0]  field_select_i,
  input  logic [15:0] field_value_i,
  input  logic [7:0]  sensor_type_i,
  input  logic [7:0]  sensor_number_i,
  input  logic [7:0]  event_type_i,
  input  logic [15:0] generator_id_i,
  input  logic [7:0]  event_data1_i,
  input  logic [7:0]  event_data2_i,
  input  logic [7:0]  event_data3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  matched_entry_o,
  output logic [7:0]  permitted_actions_o,
  output logic [3:0]  alert_policy_o,
  output logic [7:0]  severity_o,
  output logic        last_o
);
  import pefm_pkg::*;
  `include "platform_event_filter_match_core_defines.svh"

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e          state_q;
  logic [7:0]      fctl_q, ppt_q, gae_q;
  logic [IDX_W-1:0] pos_q;
  logic [4:0]      nhit_q;
  logic            out_valid_q;
  logic [1:0]      kind_q;
  logic [4:0]      entry_q;
  logic [7:0]      act_q, sev_q;
  logic [3:0]      pol_q;
  logic            last_q;

  logic            accept, out_free, filt_on, load, shift, more_hits, is_last;
  logic            out_load;
  wr_t             wr;
  ev_t             ev;
  slot_t           chain [ENTRIES+1];
  logic [ENTRIES-1:0] hits;

  assign out_free   = !out_valid_q || !out_stall_i;
  // A new transaction enters only in idle, with room in the output register.
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign filt_on    = ((ppt_q == 8'h00) || (ppt_q == 8'hFF)) && fctl_q[0];

  assign wr = '{en: accept && !op_i, entry: entry_index_i, field: field_select_i,
                value: field_value_i};
  assign ev = '{st: sensor_type_i, sn: sensor_number_i, et: event_type_i,
                gid: generator_id_i, d1: event_data1_i, d2: event_data2_i,
                d3: event_data3_i};
  assign load  = accept && op_i && filt_on;
  assign shift = (state_q == ST_SCAN) && out_free;

  // Output register is loaded by a direct answer, a hit, or the end of a dry scan.
  assign out_load = (accept && (!op_i || !filt_on))
                    || (shift && (chain[0].hit || (pos_q == IDX_W'(ENTRIES - 1))));

  assign chain[ENTRIES] = '0;
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    pefm_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i  (IDX_W'(k)),
      .wr_i   (wr),
      .ev_i   (ev),
      .load_i (load),
      .shift_i(shift),
      .slot_i (chain[k+1]),
      .slot_o (chain[k])
    );
    assign hits[k] = chain[k].hit;
  end

  // Hits behind the head, the hit limit and the last position decide whether the head hit is the final result.
  assign more_hits = (hits >> 1) != '0;
  assign is_last   = !more_hits || (nhit_q == 5'(MAX_HITS - 1))
                     || (pos_q == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fctl_q <= '0; ppt_q <= '0; gae_q <= '0;
      pos_q <= '0; nhit_q <= '0;
      out_valid_q <= 1'b0;
      kind_q <= KIND_WRITE; entry_q <= '0; act_q <= '0; pol_q <= '0;
      sev_q <= '0; last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FILTER_CTRL: fctl_q <= cfg_wdata_i;
          REG_POSTPONE:    ppt_q  <= cfg_wdata_i;
          REG_ACTION_EN:   gae_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!op_i || !filt_on) begin
              kind_q  <= op_i ? KIND_OFF : KIND_WRITE;
              entry_q <= '0; act_q <= '0; pol_q <= '0; sev_q <= '0;
              last_q  <= 1'b1;
            end else begin
              state_q <= ST_SCAN;
              pos_q   <= '0;
              nhit_q  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (shift) begin
            pos_q <= pos_q + 1'b1;
            if (chain[0].hit) begin
              kind_q  <= KIND_MATCH;
              entry_q <= 5'(pos_q);
              act_q   <= chain[0].act & gae_q;
              pol_q   <= chain[0].pol;
              sev_q   <= chain[0].sev;
              last_q  <= is_last;
              nhit_q  <= nhit_q + 1'b1;
              if (is_last) state_q <= ST_IDLE;
            end else if (pos_q == IDX_W'(ENTRIES - 1)) begin
              kind_q  <= KIND_NOMATCH;
              entry_q <= '0; act_q <= '0; pol_q <= '0; sev_q <= '0;
              last_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign matched_entry_o     = entry_q;
  assign permitted_actions_o = act_q;
  assign alert_policy_o      = pol_q;
  assign severity_o          = sev_q;
  assign last_o              = last_q;

  `PEFM_ASSERT(a_no_accept_in_scan, clk_i, rst_ni, !(state_q == ST_SCAN && accept), "accept during scan")
  `PEFM_ASSERT(a_entry0_never_hits, clk_i, rst_ni, !(out_valid_q && kind_q == KIND_MATCH && entry_q == '0), "entry zero matched")
  `PEFM_ASSERT_NEXT(a_load_scans, clk_i, rst_ni, load, state_q == ST_SCAN && pos_q == '0, "event load did not start scan")
endmodule

[sv/pefm_cell.sv]
// One filter table entry: field storage, match test and one result slot
// of the shift chain. Depends on pefm_pkg.
module pefm_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [pefm_pkg::IDX_W-1:0] idx_i,
  input  pefm_pkg::wr_t           wr_i,
  input  pefm_pkg::ev_t           ev_i,
  input  logic                    load_i,
  input  logic                    shift_i,
  input  pefm_pkg::slot_t         slot_i,
  output pefm_pkg::slot_t         slot_o
);
  import pefm_pkg::*;

  logic [47:0] ids_q, ids_d;
  logic [23:0] r1_q, r1_d, r2_q, r2_d, r3_q, r3_d, act_q, act_d;
  logic [15:0] om_q, om_d;
  slot_t       slot_q, slot_d;
  logic        sel, match;
  logic [7:0]  b;

  assign sel = wr_i.en && ({1'b0, wr_i.entry} == 6'(idx_i));
  assign b   = wr_i.value[7:0];

  always_comb begin
    ids_d = ids_q; r1_d = r1_q; r2_d = r2_q; r3_d = r3_q;
    om_d = om_q; act_d = act_q;
    if (sel) begin
      if (wr_i.field <= FLD_TRIGGER) begin
        ids_d[8*wr_i.field[2:0] +: 8] = b;
      end else if (wr_i.field < FLD_D2_MASK) begin
        r1_d[8*(wr_i.field - FLD_D1_MASK) +: 8] = b;
      end else if (wr_i.field < FLD_D3_MASK) begin
        r2_d[8*(wr_i.field - FLD_D2_MASK) +: 8] = b;
      end else if (wr_i.field < FLD_OFFSET) begin
        r3_d[8*(wr_i.field - FLD_D3_MASK) +: 8] = b;
      end else if (wr_i.field == FLD_OFFSET) begin
        om_d = wr_i.value;
      end else if (wr_i.field <= FLD_SEVERITY) begin
        act_d[8*(wr_i.field - FLD_ACTION) +: 8] = b;
      end
    end
  end

  assign match = (idx_i != '0) && ids_q[7]
      && id_ok(ids_q[15:8], ev_i.gid[15:8]) && id_ok(ids_q[23:16], ev_i.gid[7:0])
      && (ev_i.st != 8'h00) && id_ok(ids_q[31:24], ev_i.st)
      && id_ok(ids_q[39:32], ev_i.sn) && id_ok(ids_q[47:40], ev_i.et)
      && rule_pass(ev_i.d1, r1_q) && rule_pass(ev_i.d2, r2_q)
      && rule_pass(ev_i.d3, r3_q) && om_q[ev_i.d1[3:0]];

  always_comb begin
    slot_d = slot_q;
    if (load_i) slot_d = '{hit: match, act: act_q[7:0], pol: act_q[11:8], sev: act_q[23:16]};
    else if (shift_i) slot_d = slot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0; om_q <= '0; act_q <= '0;
      slot_q <= '0;
    end else begin
      ids_q <= ids_d; r1_q <= r1_d; r2_q <= r2_d; r3_q <= r3_d;
      om_q <= om_d; act_q <= act_d; slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule
